// File: rtl/core/tdr_pkg.sv
`timescale 1ns / 1ps

package tdr_pkg;

	// Field widths of the stream items.
	localparam int STATE_W   = 4;
	localparam int SYM_W     = 8;
	localparam int ENTRY_W   = STATE_W + 1;   // valid bit above next state
	localparam int ACC_DEPTH = 1 << STATE_W;

	localparam logic [SYM_W-1:0] NEWLINE_BYTE = 8'd10;

	typedef enum logic [1:0] {
		REQ_TRANS  = 2'd0,
		REQ_ACCEPT = 2'd1,
		REQ_SYMBOL = 2'd2,
		REQ_END    = 2'd3
	} req_t;

endpackage

// File: rtl/core/tdr_trans_mem.sv
`timescale 1ns / 1ps

module tdr_trans_mem #(
	parameter int AW = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [tdr_pkg::ENTRY_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [tdr_pkg::ENTRY_W-1:0] wr_data,
	output logic                       busy
);
	import tdr_pkg::*;

	localparam int Depth = 1 << AW;

	logic [ENTRY_W-1:0] mem [Depth];
	logic [ENTRY_W-1:0] rd_q;
	logic [AW-1:0]      clr_q;
	logic               busy_q;

	logic               we;
	logic [AW-1:0]      wa;
	logic [ENTRY_W-1:0] wd;

	// The clearing sweep owns the write port until every entry is zero.
	assign we = busy_q | wr_en;
	assign wa = busy_q ? clr_q : wr_addr;
	assign wd = busy_q ? '0 : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign busy    = busy_q;

endmodule

// File: rtl/core/table_dfa_recognizer_top.sv
`timescale 1ns / 1ps

// Table-driven byte recognizer.
// Items arrive on the s_ stream: s_tuser carries the request kind (write
// transition, write accept flag, symbol, end of word), s_tdata the payload.
// Each ended word (an end item, or a symbol transfer carrying a newline)
// gives one result transfer on the m_ stream in the cycle after the ending item
// is taken; load items and ordinary symbols give none.
// One item is taken every cycle after the sweep, while the result register is
// free or being drained. The figure is set by the transition memory: its
// registered read data selects the next lookup address in the same cycle.
// The start state comes in on the cfg_ channel, which is always ready; a write
// also restarts the current word.
// After reset the transition memory is swept to zero, one entry a cycle: all
// 2**(ceil(log2(min(NUM_STATES,16))) + ceil(log2(NUM_SYMBOLS))) entries
// (4096 with the default parameters). s_tready stays low during the sweep.
// Accept flags clear at once and the start state returns to zero.
// When the receiver stalls, the pending result is held and s_tready drops
// until it has been taken.
module table_dfa_recognizer_top #(
	parameter int NUM_STATES  = 16,
	parameter int NUM_SYMBOLS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // req_type
	input  logic [23:0] s_tdata,   // symbol, from_state, to_state, entry_valid,
	                               // accept_bit, zero fill
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // accepted, final_state, zero fill
	// Start state register.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import tdr_pkg::*;

	// Only sixteen states can be named by the four-bit state fields.
	localparam int NsEff = (NUM_STATES < ACC_DEPTH) ? NUM_STATES : ACC_DEPTH;
	localparam int SW    = $clog2(NsEff);
	localparam int YW    = $clog2(NUM_SYMBOLS);
	localparam int AW    = SW + YW;
	localparam logic [8:0] NsLim  = 9'(NUM_STATES);
	localparam logic [8:0] SymLim = 9'(NUM_SYMBOLS);

	// Unpacked input fields.
	req_t               req_type;
	logic [SYM_W-1:0]   symbol;
	logic [STATE_W-1:0] from_state;
	logic [STATE_W-1:0] to_state;
	logic               entry_valid;
	logic               accept_bit;

	assign req_type    = req_t'(s_tuser);
	assign symbol      = s_tdata[7:0];
	assign from_state  = s_tdata[11:8];
	assign to_state    = s_tdata[15:12];
	assign entry_valid = s_tdata[16];
	assign accept_bit  = s_tdata[17];

	// Walk state. When look_s1 is set, the entry read last cycle decides the
	// current state; cur_q then still holds the state the lookup started from,
	// which is also the state reported if that lookup rejects the word.
	logic [STATE_W-1:0]   start_q;
	logic [STATE_W-1:0]   cur_q;
	logic                 rej_q;
	logic                 look_s1;
	logic [ACC_DEPTH-1:0] acc_q;
	logic                 out_valid_q;
	logic                 out_acc_q;
	logic [STATE_W-1:0]   out_state_q;

	logic [STATE_W-1:0] eff_state;
	logic               eff_rej;
	logic [ENTRY_W-1:0] rd_data;
	logic               mem_busy;

	logic take;
	logic is_sym;
	logic is_end;
	logic sym_ok;
	logic from_ok;
	logic to_ok;
	logic state_ok;
	logic lookup;
	logic reject_now;
	logic wr_en;
	logic [ENTRY_W-1:0] wr_data;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;

	always_comb begin
		if (look_s1) begin
			eff_rej   = !rd_data[ENTRY_W-1];
			eff_state = rd_data[ENTRY_W-1] ? rd_data[STATE_W-1:0] : cur_q;
		end else begin
			eff_rej   = rej_q;
			eff_state = cur_q;
		end
	end

	assign s_tready = !mem_busy && (!out_valid_q || m_tready);
	assign take     = s_tvalid && s_tready;

	assign is_sym   = (req_type == REQ_SYMBOL) && (symbol != NEWLINE_BYTE);
	assign is_end   = (req_type == REQ_END) ||
	                  ((req_type == REQ_SYMBOL) && (symbol == NEWLINE_BYTE));
	assign sym_ok   = {1'b0, symbol} < SymLim;
	assign from_ok  = {5'b0, from_state} < NsLim;
	assign to_ok    = {5'b0, to_state} < NsLim;
	assign state_ok = {5'b0, eff_state} < NsLim;

	// A symbol either starts a lookup or, with no table entry possible,
	// rejects the word straight away. A rejected word ignores its symbols.
	assign lookup     = take && is_sym && !eff_rej && sym_ok && state_ok;
	assign reject_now = take && is_sym && !eff_rej && !(sym_ok && state_ok);

	assign rd_addr = {eff_state[SW-1:0], symbol[YW-1:0]};
	assign wr_addr = {from_state[SW-1:0], symbol[YW-1:0]};
	assign wr_en   = take && (req_type == REQ_TRANS) && from_ok && sym_ok;
	assign wr_data = {entry_valid && to_ok, to_state};

	tdr_trans_mem #(
		.AW(AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (lookup),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.busy    (mem_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			cur_q       <= '0;
			rej_q       <= 1'b0;
			look_s1     <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_acc_q   <= 1'b0;
			out_state_q <= '0;
		end else begin
			// Fold any finished lookup into the stored state.
			look_s1 <= lookup;
			cur_q   <= eff_state;
			rej_q   <= eff_rej || reject_now;

			if (take && (req_type == REQ_ACCEPT) && from_ok) begin
				acc_q[from_state] <= accept_bit;
			end

			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (take && is_end) begin
				out_valid_q <= 1'b1;
				out_acc_q   <= !eff_rej && state_ok && acc_q[eff_state];
				out_state_q <= eff_state;
				cur_q       <= start_q;
				rej_q       <= !({5'b0, start_q} < NsLim);
			end

			// A start state write restarts the word from the new state.
			if (cfg_valid) begin
				start_q <= cfg_data;
				cur_q   <= cfg_data;
				rej_q   <= !({5'b0, cfg_data} < NsLim);
				look_s1 <= 1'b0;
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {3'b000, out_state_q, out_acc_q};

endmodule

// File: rtl/core/tdr_checker.sv
`timescale 1ns / 1ps

module tdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);
	import tdr_pkg::*;

	// A held result keeps its value until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// No item is taken while a result is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result slot full");

	// An end item gives a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_END) |=> m_tvalid)
		else $error("end item gave no result");

	// Load items never give a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_TRANS || s_tuser == REQ_ACCEPT) &&
		(!m_tvalid || m_tready) |=> !m_tvalid)
		else $error("load item gave a result");

endmodule

bind table_dfa_recognizer_top tdr_checker u_tdr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
